FILE: hdl/extracellular_potential_estimator_assert.svh
// assertion macros used by the engine
`ifndef EXTRACELLULAR_POTENTIAL_ESTIMATOR_ASSERT_SVH
`define EXTRACELLULAR_POTENTIAL_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define EPE_ASSERT_IMPL(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define EPE_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

FILE: hdl/epe_pkg.sv
`timescale 1ns / 1ps
package epe_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // one input item as held in the queue
  typedef struct packed {
    logic               operation;
    logic signed [23:0] mid_x;
    logic signed [23:0] mid_y;
    logic signed [23:0] mid_z;
    logic signed [31:0] current;
    logic [31:0]        sample_time;
    logic               last_element;
  } item_t;

  // electrode coordinates [electrode][axis] and coupling scale
  typedef struct packed {
    logic [1:0][2:0][23:0] elec;
    logic [31:0]           scale;
  } cfg_t;

  // status of the root and divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } rd_status_t;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage

FILE: hdl/epe_front_queue.sv
`timescale 1ns / 1ps
module epe_front_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  epe_pkg::item_t in_item,
  output logic           head_valid,
  output epe_pkg::item_t head,
  input  logic           pop
);

  epe_pkg::item_t q [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           push;
  logic           take;

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign take       = pop && (count != 2'd0);
  assign head_valid = (count != 2'd0);
  assign head       = q[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (take) rptr <= ~rptr;
      if (push && !take) count <= count + 2'd1;
      else if (take && !push) count <= count - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) q[wptr] <= in_item;
  end

endmodule

FILE: hdl/epe_root_div.sv
`timescale 1ns / 1ps
module epe_root_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [51:0]         dist_sq,
  input  logic [31:0]         scale,
  output logic [31:0]         response,
  output epe_pkg::rd_status_t status
);

  typedef enum logic [1:0] {RD_IDLE, RD_ROOT, RD_DIV, RD_DONE} rd_state_t;

  rd_state_t   state;
  logic [5:0]  step;
  logic [59:0] rad;
  logic [32:0] rem_r;
  logic [29:0] root;
  logic [29:0] rem_d;
  logic [31:0] quo;

  logic [32:0] rem_shift;
  logic [32:0] trial;
  logic        root_ok;
  logic [30:0] div_shift;
  logic        div_ok;

  // one root digit per cycle
  assign rem_shift = {rem_r[30:0], rad[59:58]};
  assign trial     = {1'b0, root, 2'b01};
  assign root_ok   = (rem_shift >= trial);

  // one quotient bit per cycle
  assign div_shift = {rem_d, quo[31]};
  assign div_ok    = (div_shift >= {1'b0, root});

  assign status.busy = (state != RD_IDLE);
  assign status.done = (state == RD_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RD_IDLE;
    end else begin
      case (state)
        RD_IDLE: begin
          if (start) begin
            if (dist_sq == 52'd0) begin
              response <= 32'hFFFF_FFFF;
              state    <= RD_DONE;
            end else begin
              rad   <= {dist_sq, 8'd0};
              rem_r <= 33'd0;
              root  <= 30'd0;
              step  <= 6'd0;
              state <= RD_ROOT;
            end
          end
        end
        RD_ROOT: begin
          rad <= {rad[57:0], 2'b00};
          if (root_ok) begin
            rem_r <= rem_shift - trial;
            root  <= {root[28:0], 1'b1};
          end else begin
            rem_r <= rem_shift;
            root  <= {root[28:0], 1'b0};
          end
          if (step == 6'd29) begin
            step  <= 6'd0;
            rem_d <= 30'd0;
            quo   <= scale;
            state <= RD_DIV;
          end else begin
            step <= step + 6'd1;
          end
        end
        RD_DIV: begin
          if (div_ok) begin
            rem_d <= 30'(div_shift - {1'b0, root});
            quo   <= {quo[30:0], 1'b1};
          end else begin
            rem_d <= div_shift[29:0];
            quo   <= {quo[30:0], 1'b0};
          end
          if (step == 6'd31) begin
            state <= RD_DONE;
            if (div_ok) response <= {quo[30:0], 1'b1};
            else response <= {quo[30:0], 1'b0};
          end else begin
            step <= step + 6'd1;
          end
        end
        RD_DONE: state <= RD_IDLE;
        default: state <= RD_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/epe_engine.sv
`timescale 1ns / 1ps
module epe_engine #(
  parameter int MAX_SOURCES    = 256,
  parameter int NUM_ELECTRODES = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  epe_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  epe_pkg::item_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               electrode,
  output logic signed [47:0] potential,
  output logic [31:0]        time_out,
  output logic               last_of_run
);

`include "extracellular_potential_estimator_assert.svh"

  localparam int CW    = $clog2(MAX_SOURCES + 1);
  localparam int DEPTH = NUM_ELECTRODES * MAX_SOURCES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_SQ, ST_LD_START, ST_LD_WAIT,
    ST_SM_READ, ST_SM_MUL, ST_SM_ACC, ST_EMIT, ST_OUT
  } st_t;

  st_t                state;
  epe_pkg::item_t     item;
  logic               e;
  logic [1:0]         k;
  logic [51:0]        dsum;
  logic [CW-1:0]      load_index;
  logic [CW-1:0]      source_index;
  logic signed [47:0] acc [NUM_ELECTRODES];
  logic [31:0]        rd_data;
  logic signed [63:0] prod;
  logic               rd_start;
  logic               wr_en;
  logic [31:0]        wr_data;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        resp_mem [DEPTH];

  logic [31:0]         response;
  epe_pkg::rd_status_t rd_status;

  logic signed [23:0] mid_sel;
  logic signed [23:0] ec_sel;
  logic signed [24:0] diff;
  logic signed [49:0] sq;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      ld_addr;
  logic signed [64:0] prod_full;
  logic signed [47:0] term;
  logic signed [48:0] sum;
  logic signed [47:0] sat;

  epe_root_div u_root_div (
    .clk      (clk),
    .rst      (rst),
    .start    (rd_start),
    .dist_sq  (dsum),
    .scale    (cfg.scale),
    .response (response),
    .status   (rd_status)
  );

  // coordinate difference for the current axis and electrode
  always_comb begin
    case (k)
      2'd0: begin
        mid_sel = item.mid_x;
        ec_sel  = $signed(cfg.elec[e][0]);
      end
      2'd1: begin
        mid_sel = item.mid_y;
        ec_sel  = $signed(cfg.elec[e][1]);
      end
      default: begin
        mid_sel = item.mid_z;
        ec_sel  = $signed(cfg.elec[e][2]);
      end
    endcase
  end

  assign diff = {mid_sel[23], mid_sel} - {ec_sel[23], ec_sel};
  assign sq   = diff * diff;

  // table addresses, electrode block then source
  assign rd_addr = AW'(32'(e) * MAX_SOURCES + 32'(source_index));
  assign ld_addr = AW'(32'(e) * MAX_SOURCES + 32'(load_index));

  // product, floor to q16 and saturating add
  assign prod_full = item.current * $signed({1'b0, rd_data});
  assign term      = prod[63:16];
  assign sum       = {term[47], term} + {acc[e][47], acc[e]};
  always_comb begin
    if (sum[48] != sum[47]) sat = sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else sat = sum[47:0];
  end

  assign pop = (state == ST_IDLE) && head_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      load_index   <= '0;
      source_index <= '0;
      out_valid    <= 1'b0;
      rd_start     <= 1'b0;
      wr_en        <= 1'b0;
      e            <= 1'b0;
      k            <= 2'd0;
      for (int i = 0; i < NUM_ELECTRODES; i++) acc[i] <= '0;
    end else begin
      rd_start <= 1'b0;
      wr_en    <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (head_valid) begin
            item <= head;
            e    <= 1'b0;
            k    <= 2'd0;
            dsum <= 52'd0;
            if (head.operation == epe_pkg::OP_LOAD) begin
              if (load_index < CW'(MAX_SOURCES)) state <= ST_LD_SQ;
              else if (head.last_element) load_index <= '0;
            end else begin
              if (source_index < CW'(MAX_SOURCES)) state <= ST_SM_READ;
              else if (head.last_element) state <= ST_EMIT;
            end
          end
        end
        ST_LD_SQ: begin
          dsum <= dsum + {2'b00, sq};
          if (k == 2'd2) state <= ST_LD_START;
          else k <= k + 2'd1;
        end
        ST_LD_START: begin
          rd_start <= 1'b1;
          state    <= ST_LD_WAIT;
        end
        ST_LD_WAIT: begin
          if (rd_status.done) begin
            wr_en   <= 1'b1;
            wr_addr <= ld_addr;
            wr_data <= response;
            if (32'(e) == NUM_ELECTRODES - 1) begin
              load_index <= item.last_element ? '0 : load_index + CW'(1);
              state      <= ST_IDLE;
            end else begin
              e     <= 1'b1;
              k     <= 2'd0;
              dsum  <= 52'd0;
              state <= ST_LD_SQ;
            end
          end
        end
        ST_SM_READ: state <= ST_SM_MUL;
        ST_SM_MUL: begin
          prod  <= prod_full[63:0];
          state <= ST_SM_ACC;
        end
        ST_SM_ACC: begin
          acc[e] <= sat;
          if (32'(e) == NUM_ELECTRODES - 1) begin
            source_index <= source_index + CW'(1);
            e            <= 1'b0;
            state        <= item.last_element ? ST_EMIT : ST_IDLE;
          end else begin
            e     <= 1'b1;
            state <= ST_SM_READ;
          end
        end
        ST_EMIT: begin
          out_valid   <= 1'b1;
          electrode   <= e;
          potential   <= acc[e];
          time_out    <= item.sample_time;
          last_of_run <= (32'(e) == NUM_ELECTRODES - 1);
          acc[e]      <= '0;
          state       <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_of_run) begin
              source_index <= '0;
              e            <= 1'b0;
              state        <= ST_IDLE;
            end else begin
              e     <= 1'b1;
              state <= ST_EMIT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // response table
  always_ff @(posedge clk) begin
    if (wr_en) resp_mem[wr_addr] <= wr_data;
    if (state == ST_SM_READ) rd_data <= resp_mem[rd_addr];
  end

  `EPE_ASSERT_IMPL(a_valid_in_out, clk, rst, out_valid, state == ST_OUT, "stray result")
  `EPE_ASSERT_NEXT(a_run_ends, clk, rst, out_valid && !out_stall && last_of_run, !out_valid && state == ST_IDLE, "run not ended")
  `EPE_ASSERT_IMPL(a_done_waited, clk, rst, rd_status.done, state == ST_LD_WAIT, "stray response")

endmodule

FILE: hdl/extracellular_potential_estimator.sv
`timescale 1ns / 1ps
// channel  | handshake             | payload
// input    | in_valid / in_stall   | operation mid_x mid_y mid_z current sample_time last_element
// output   | out_valid / out_stall | electrode potential time_out last_of_run
// config   | cfg_we                | cfg_index cfg_data
//
// a sample item is dequeued, then for each electrode passes the registered table read,
// the shared product register and the saturating accumulate.
// a load item sums the squared axis differences per electrode, then waits on the
// bit-serial root and the restoring divider in the root and divide unit, which skips
// both when the midpoint sits on the electrode.
// a sample's last item then adds an emit and an output state per electrode result, plus output stall time.
// reset is synchronous; the response table is not cleared and needs no sweep.
// a two-entry queue takes up to two items while the engine or output stalls.
module extracellular_potential_estimator #(
  parameter int MAX_SOURCES    = 256,
  parameter int NUM_ELECTRODES = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             operation,
  input  logic signed [23:0]               mid_x,
  input  logic signed [23:0]               mid_y,
  input  logic signed [23:0]               mid_z,
  input  logic signed [31:0]               current,
  input  logic [31:0]                      sample_time,
  input  logic                             last_element,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             electrode,
  output logic signed [47:0]               potential,
  output logic [31:0]                      time_out,
  output logic                             last_of_run,
  input  logic                             cfg_we,
  input  logic [epe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [epe_pkg::CFG_IDX_W-1:0] REG_A_X   = 3'd0;
  localparam logic [epe_pkg::CFG_IDX_W-1:0] REG_A_Y   = 3'd1;
  localparam logic [epe_pkg::CFG_IDX_W-1:0] REG_A_Z   = 3'd2;
  localparam logic [epe_pkg::CFG_IDX_W-1:0] REG_B_X   = 3'd3;
  localparam logic [epe_pkg::CFG_IDX_W-1:0] REG_B_Y   = 3'd4;
  localparam logic [epe_pkg::CFG_IDX_W-1:0] REG_B_Z   = 3'd5;
  localparam logic [epe_pkg::CFG_IDX_W-1:0] REG_SCALE = 3'd6;

  epe_pkg::cfg_t  cfg;
  epe_pkg::item_t in_item;
  epe_pkg::item_t head;
  logic           head_valid;
  logic           pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_X:   cfg.elec[0][0] <= cfg_data[23:0];
        REG_A_Y:   cfg.elec[0][1] <= cfg_data[23:0];
        REG_A_Z:   cfg.elec[0][2] <= cfg_data[23:0];
        REG_B_X:   cfg.elec[1][0] <= cfg_data[23:0];
        REG_B_Y:   cfg.elec[1][1] <= cfg_data[23:0];
        REG_B_Z:   cfg.elec[1][2] <= cfg_data[23:0];
        REG_SCALE: cfg.scale      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item = '{operation: operation, mid_x: mid_x, mid_y: mid_y, mid_z: mid_z,
                     current: current, sample_time: sample_time,
                     last_element: last_element};

  epe_front_queue u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  epe_engine #(
    .MAX_SOURCES    (MAX_SOURCES),
    .NUM_ELECTRODES (NUM_ELECTRODES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .electrode   (electrode),
    .potential   (potential),
    .time_out    (time_out),
    .last_of_run (last_of_run)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int MAX_SRC = 256;
  localparam int SETTLE = 400;
  localparam int REG_A_X = 0, REG_A_Y = 1, REG_A_Z = 2;
  localparam int REG_B_X = 3, REG_B_Y = 4, REG_B_Z = 5, REG_SCALE = 6;
  localparam logic signed [47:0] POT_MAX = 48'sh7FFFFFFFFFFF;
  localparam logic signed [47:0] POT_MIN = -48'sh7FFFFFFFFFFF - 1;

  typedef struct {
    logic               elec;
    logic signed [47:0] pot;
    logic [31:0]        stamp;
    logic               fin;
  } potential_t;

  typedef struct {
    logic               op;
    logic signed [23:0] x, y, z;
    logic signed [31:0] cur;
    logic [31:0]        stamp;
    logic               fin;
    bit                 typed;
    logic signed [47:0] pot_a, pot_b;
  } stim_row_t;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic operation = epe_pkg::OP_LOAD;
  logic signed [23:0] mid_x = '0, mid_y = '0, mid_z = '0;
  logic signed [31:0] current = '0;
  logic [31:0] sample_time = '0;
  logic last_element = 1'b0;
  logic out_valid, out_stall = 1'b0;
  logic electrode, last_of_run;
  logic signed [47:0] potential;
  logic [31:0] time_out;
  logic cfg_we = 1'b0;
  logic [epe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [epe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic signed [23:0] elec_pos [2][3];
  logic [31:0] coupling;
  logic [31:0] response_mem [2][MAX_SRC];
  logic signed [47:0] acc [2];
  int load_ptr, source_ptr;
  potential_t pending_pots[$];

  bit failed = 1'b0;
  int hold_cycles = 0;
  int gap_max = 19;
  int items_sent = 0;

  extracellular_potential_estimator i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("extracellular_potential_estimator: mismatch");
    $finish;
  end

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // coupling scale over distance, saturating at zero distance
  function automatic logic [31:0] calc_response(logic signed [23:0] x, y, z, int e);
    longint dx, dy, dz;
    logic [63:0] d, q;
    dx = longint'(x) - longint'(elec_pos[e][0]);
    dy = longint'(y) - longint'(elec_pos[e][1]);
    dz = longint'(z) - longint'(elec_pos[e][2]);
    d = dx * dx + dy * dy + dz * dz;
    if (d == 0) return 32'hFFFFFFFF;
    q = int_root(d << 8);
    return 32'({32'b0, coupling} / q);
  endfunction

  function automatic void write_reg(int idx, logic [31:0] data);
    if (idx == REG_SCALE) coupling = data;
    else elec_pos[idx / 3][idx % 3] = data[23:0];
  endfunction

  // advance the predictor by one item, queue the potentials it yields
  function automatic void predict_item(logic op, logic signed [23:0] x, y, z,
                                       logic signed [31:0] cur, logic [31:0] stamp,
                                       logic fin);
    longint p, s;
    potential_t r;
    if (op == epe_pkg::OP_LOAD) begin
      if (load_ptr < MAX_SRC) begin
        for (int e = 0; e < 2; e++) response_mem[e][load_ptr] = calc_response(x, y, z, e);
        load_ptr++;
      end
      if (fin) load_ptr = 0;
      return;
    end
    if (source_ptr < MAX_SRC) begin
      for (int e = 0; e < 2; e++) begin
        p = longint'(cur) * longint'({32'b0, response_mem[e][source_ptr]});
        s = longint'(acc[e]) + (p >>> 16);
        if (s > longint'(POT_MAX)) s = longint'(POT_MAX);
        if (s < longint'(POT_MIN)) s = longint'(POT_MIN);
        acc[e] = s[47:0];
      end
      source_ptr++;
    end
    if (!fin) return;
    for (int e = 0; e < 2; e++) begin
      r.elec = e[0];
      r.pot = acc[e];
      r.stamp = stamp;
      r.fin = (e == 1);
      pending_pots = {pending_pots, r};
      acc[e] = '0;
    end
    source_ptr = 0;
  endfunction

  // offer one item, keep valid high across back-to-back items
  task automatic send_item(logic op, logic signed [23:0] x, y, z,
                           logic signed [31:0] cur, logic [31:0] stamp, logic fin);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    mid_x <= x;
    mid_y <= y;
    mid_z <= z;
    current <= cur;
    sample_time <= stamp;
    last_element <= fin;
    do @(posedge clk); while (in_stall);
    predict_item(op, x, y, z, cur, stamp, fin);
    items_sent++;
  endtask

  // wait out results and any load still in the engine
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_pots.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write enable stays high across a burst, the caller drops it
  task automatic cfg_write(int idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx[epe_pkg::CFG_IDX_W-1:0];
    cfg_data <= data;
    @(posedge clk);
    write_reg(idx, data);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 4095)) - 24'd2048;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_current();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 65535)) - 32'd32768;
      default: return $urandom;
    endcase
  endfunction

  // midpoints sometimes sit on an electrode to hit the zero distance case
  task automatic send_load(logic fin);
    int pick;
    logic signed [23:0] x, y, z;
    pick = $urandom_range(0, 7);
    if (pick < 2) begin
      x = elec_pos[pick][0];
      y = elec_pos[pick][1];
      z = elec_pos[pick][2];
    end else begin
      x = rand_coord();
      y = rand_coord();
      z = rand_coord();
    end
    send_item(epe_pkg::OP_LOAD, x, y, z, $urandom, $urandom, fin);
  endtask

  task automatic config_phase(int mode);
    for (int i = 0; i <= REG_B_Z; i++) begin
      case (mode)
        0: cfg_write(i, 32'h007FFFFF);
        1: cfg_write(i, 32'h00800000);
        default: cfg_write(i, {8'($urandom), rand_coord()});
      endcase
    end
    case (mode)
      0: cfg_write(REG_SCALE, 32'hFFFFFFFF);
      1: cfg_write(REG_SCALE, 32'h0);
      default: cfg_write(REG_SCALE, $urandom);
    endcase
    cfg_we <= 1'b0;
  endtask

  // result side: random stall per item, plus long hold-offs on request
  initial begin
    int w;
    potential_t exp_pot;
    @(negedge rst);
    forever begin
      w = $urandom_range(0, 1) ? $urandom_range(0, 19) : 0;
      if (hold_cycles > 0) begin
        w = hold_cycles;
        hold_cycles = 0;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if (pending_pots.size() == 0) begin
        $display("%0t unexpected item: electrode %0d potential %h", $time, electrode,
                 potential);
        failed = 1'b1;
      end else begin
        exp_pot = pending_pots.pop_front();
        if (electrode !== exp_pot.elec) begin
          $display("%0t electrode: expected %0d got %0d", $time, exp_pot.elec, electrode);
          failed = 1'b1;
        end
        if (potential !== exp_pot.pot) begin
          $display("%0t potential: expected %h got %h", $time, exp_pot.pot, potential);
          failed = 1'b1;
        end
        if (time_out !== exp_pot.stamp) begin
          $display("%0t time_out: expected %h got %h", $time, exp_pot.stamp, time_out);
          failed = 1'b1;
        end
        if (last_of_run !== exp_pot.fin) begin
          $display("%0t last_of_run: expected %0d got %0d", $time, exp_pot.fin,
                   last_of_run);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    stim_row_t rows [14];
    stim_row_t row;
    int nsrc, nsamp, len, phase, n;

    for (int e = 0; e < 2; e++) begin
      acc[e] = '0;
      for (int a = 0; a < 3; a++) elec_pos[e][a] = '0;
    end
    coupling = '0;
    load_ptr = 0;
    source_ptr = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: electrode a at origin, b at 16 along x, full scale
    cfg_write(REG_SCALE, 32'hFFFFFFFF);
    cfg_write(REG_B_X, 32'd16);
    cfg_we <= 1'b0;
    rows = '{
      '{epe_pkg::OP_LOAD, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0},
      '{epe_pkg::OP_LOAD, 16, 0, 0, 0, 0, 1'b1, 1'b0, 0, 0},
      '{epe_pkg::OP_SAMPLE, 0, 0, 0, 32'h00010000, 5, 1'b0, 1'b0, 0, 0},
      '{epe_pkg::OP_SAMPLE, 0, 0, 0, 0, 32'hFFFFFFFF, 1'b1, 1'b1,
        48'sh0000FFFFFFFF, 48'sh000000FFFFFF},
      '{epe_pkg::OP_SAMPLE, 0, 0, 0, -32'sh00010000, 0, 1'b1, 1'b1,
        -48'sh0000FFFFFFFF, -48'sh000000FFFFFF},
      '{epe_pkg::OP_SAMPLE, 0, 0, 0, 32'h7FFFFFFF, 7, 1'b0, 1'b0, 0, 0},
      '{epe_pkg::OP_SAMPLE, 0, 0, 0, 32'h7FFFFFFF, 8, 1'b1, 1'b0, 0, 0},
      '{epe_pkg::OP_SAMPLE, 0, 0, 0, 32'h80000000, 9, 1'b0, 1'b0, 0, 0},
      '{epe_pkg::OP_SAMPLE, 0, 0, 0, 32'h80000000, 10, 1'b1, 1'b0, 0, 0},
      '{epe_pkg::OP_SAMPLE, 0, 0, 0, 32'h0, 11, 1'b1, 1'b1, 0, 0},
      '{epe_pkg::OP_LOAD, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, 0, 1'b0, 1'b0, 0, 0},
      '{epe_pkg::OP_LOAD, 24'h800000, 24'h7FFFFF, 24'h800000, 0, 0, 1'b1, 1'b0, 0, 0},
      '{epe_pkg::OP_SAMPLE, 0, 0, 0, 32'h7FFFFFFF, 12, 1'b0, 1'b0, 0, 0},
      '{epe_pkg::OP_SAMPLE, 0, 0, 0, 32'h80000000, 13, 1'b1, 1'b0, 0, 0}
    };
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.op, row.x, row.y, row.z, row.cur, row.stamp, row.fin);
      // swap in the hand-worked values for rows that carry them
      if (row.typed) begin
        n = pending_pots.size();
        pending_pots[n - 2].pot = row.pot_a;
        pending_pots[n - 1].pot = row.pot_b;
      end
    end
    drain();

    // fill the whole table, two loads past the end, then an overlong sample
    config_phase(2);
    for (int i = 0; i < MAX_SRC + 2; i++) send_load(i == MAX_SRC + 1);
    for (int i = 0; i < MAX_SRC + 2; i++)
      send_item(epe_pkg::OP_SAMPLE, 0, 0, 0, rand_current(), $urandom, i == MAX_SRC + 1);

    phase = 0;
    while (items_sent < 1540) begin
      drain();
      config_phase(phase < 2 ? phase : 2);
      gap_max = $urandom_range(0, 2) == 0 ? 0 : 19;
      nsrc = $urandom_range(0, 9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 6);
      for (int i = 0; i < nsrc; i++) send_load(i == nsrc - 1);
      if (phase == 3) hold_cycles = 600;
      nsamp = $urandom_range(3, 10);
      for (int s = 0; s < nsamp; s++) begin
        len = $urandom_range(0, 4) == 0 ? $urandom_range(1, nsrc + 2) : nsrc;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) send_load($urandom_range(0, 1));
          send_item(epe_pkg::OP_SAMPLE, 0, 0, 0, rand_current(), $urandom, i == len - 1);
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    wait (pending_pots.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (!failed && pending_pots.size() == 0) begin
      $display("extracellular_potential_estimator: match");
    end else begin
      $display("extracellular_potential_estimator: mismatch");
    end
    $finish;
  end

endmodule
